>>> design/tfa_pkg.sv
// Shared constants and control/status types of the two-region frame allocator.
package tfa_pkg;

  localparam int NUM_FRAMES    = 131072;
  localparam int KERNEL_REGION = 1024;

  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int WORD_W  = 32;
  localparam int LANE_W  = $clog2(WORD_W);
  localparam int WORDS   = (NUM_FRAMES + WORD_W - 1) / WORD_W;
  localparam int ADDR_W  = FRAME_W - LANE_W;
  localparam int CFG_W   = 18;
  localparam int CMP_W   = (FRAME_W + 1 > CFG_W) ? FRAME_W + 1 : CFG_W;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam int KERNEL_TOP      = (KERNEL_REGION < NUM_FRAMES) ? KERNEL_REGION : NUM_FRAMES;
  localparam bit USER_NONEMPTY   = (KERNEL_REGION < NUM_FRAMES);
  localparam int KERNEL_TOP_WORD = (KERNEL_TOP - 1) / WORD_W;
  localparam int USER_BASE_WORD  = USER_NONEMPTY ? KERNEL_REGION / WORD_W : 0;
  localparam int USER_TOP_WORD   = WORDS - 1;

  localparam logic [OP_W-1:0] OP_ALLOC_KERNEL = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_USER   = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE         = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLE_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLE_END   = 2'd2;

  localparam logic [CFG_W-1:0] RESERVED_RST   = 18'd0;
  localparam logic [CFG_W-1:0] HOLE_START_RST = 18'd3840;
  localparam logic [CFG_W-1:0] HOLE_END_RST   = 18'd4096;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic finish;
  } status_t;

endpackage

>>> design/tfa_ctrl.sv
// Controller state machine: map clearing pass, transaction acceptance and scan sequencing.
module tfa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  tfa_pkg::status_t status,
  output tfa_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SCAN;
      ST_CLEAR: if (status.clear_done) state_nxt = ST_IDLE;
      ST_SCAN:  if (status.finish) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign cmd.clear = (state_r == ST_CLEAR);
  assign cmd.load  = (state_r == ST_IDLE) && start;
  assign cmd.scan  = (state_r == ST_SCAN);
  assign busy      = busy_r;

endmodule

>>> design/tfa_datapath.sv
// Datapath: allocation map memory, word scan lanes, hints, configuration and result registers.
module tfa_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tfa_pkg::cmd_t                    cmd,
  output tfa_pkg::status_t                 status,
  input  logic [tfa_pkg::OP_W-1:0]         in_opcode,
  input  logic [tfa_pkg::FRAME_W-1:0]      in_frame,
  input  logic                             cfg_we,
  input  logic [tfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tfa_pkg::CFG_W-1:0]        cfg_wdata,
  output logic                             out_valid,
  output logic [tfa_pkg::FRAME_W-1:0]      out_frame_out,
  output logic                             out_ok
);

  localparam int FW = tfa_pkg::FRAME_W;
  localparam int AW = tfa_pkg::ADDR_W;
  localparam int WW = tfa_pkg::WORD_W;
  localparam int LW = tfa_pkg::LANE_W;
  localparam int CW = tfa_pkg::CMP_W;

  logic [WW-1:0] mem [tfa_pkg::WORDS];
  logic [WW-1:0] rd_data_r;

  logic [AW-1:0] word_addr_r, word_addr_nxt;
  logic          pass2_r, pass2_nxt;
  logic [tfa_pkg::OP_W-1:0] op_r;
  logic [FW-1:0] frame_r;
  logic [FW-1:0] khint_r, uhint_r;
  logic [tfa_pkg::CFG_W-1:0] reserved_r, hole_start_r, hole_end_r;
  logic          out_valid_r, out_ok_r;
  logic [FW-1:0] out_frame_r;

  logic          is_user, is_alloc, immediate, scan_end, finish, hit, free_ok;
  logic [FW-1:0] hint;
  logic [AW-1:0] hint_word, base_word, top_word, next_word, start_word, raddr;
  logic [CW-1:0] lo_c, hi_c, hint_c;
  logic [WW-1:0] usable;
  logic [LW-1:0] hit_idx;
  logic [FW-1:0] alloc_frame;
  logic [CW-1:0] alloc_inc;
  logic          we;
  logic [WW-1:0] wdata;

  function automatic logic accessible(input logic [CW-1:0] f,
                                      input logic [tfa_pkg::CFG_W-1:0] rc,
                                      input logic [tfa_pkg::CFG_W-1:0] hs,
                                      input logic [tfa_pkg::CFG_W-1:0] he);
    logic below, in_hole;
    below   = f < CW'(rc);
    in_hole = (f >= CW'(hs)) && (f < CW'(he));
    return !below && !in_hole;
  endfunction

  assign is_user   = (op_r == tfa_pkg::OP_ALLOC_USER);
  assign is_alloc  = (op_r == tfa_pkg::OP_ALLOC_KERNEL) ||
                     (is_user && tfa_pkg::USER_NONEMPTY);
  assign immediate = !is_alloc;
  assign hint      = is_user ? uhint_r : khint_r;
  assign hint_word = hint[FW-1:LW];
  assign hint_c    = CW'(hint);
  assign base_word = is_user ? AW'(tfa_pkg::USER_BASE_WORD) : '0;
  assign top_word  = is_user ? AW'(tfa_pkg::USER_TOP_WORD) : AW'(tfa_pkg::KERNEL_TOP_WORD);
  assign lo_c      = is_user ? CW'(tfa_pkg::KERNEL_REGION) : '0;
  assign hi_c      = is_user ? CW'(tfa_pkg::NUM_FRAMES) : CW'(tfa_pkg::KERNEL_TOP);

  always_comb begin
    logic [CW-1:0] fc;
    for (int i = 0; i < WW; i++) begin
      fc = CW'({word_addr_r, LW'(i)});
      usable[i] = !rd_data_r[i] && (fc >= lo_c) && (fc < hi_c) &&
                  accessible(fc, reserved_r, hole_start_r, hole_end_r) &&
                  (pass2_r ? (fc < hint_c) : (fc >= hint_c));
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (usable[i]) hit_idx = LW'(i);
    end
  end

  assign hit         = is_alloc && (|usable);
  assign scan_end    = pass2_r && (word_addr_r == hint_word);
  assign finish      = immediate || hit || scan_end;
  assign alloc_frame = {word_addr_r, hit_idx};
  assign alloc_inc   = CW'(alloc_frame) + CW'(1);
  assign free_ok     = (op_r == tfa_pkg::OP_FREE) &&
                       (CW'(frame_r) < CW'(tfa_pkg::NUM_FRAMES)) &&
                       accessible(CW'(frame_r), reserved_r, hole_start_r, hole_end_r);

  always_comb begin
    pass2_nxt = pass2_r;
    if (pass2_r) begin
      next_word = word_addr_r + AW'(1);
    end else if (word_addr_r == top_word) begin
      next_word = base_word;
      pass2_nxt = 1'b1;
    end else begin
      next_word = word_addr_r + AW'(1);
    end
  end

  always_comb begin
    unique case (in_opcode)
      tfa_pkg::OP_ALLOC_USER: start_word = uhint_r[FW-1:LW];
      tfa_pkg::OP_FREE:       start_word = in_frame[FW-1:LW];
      default:                start_word = khint_r[FW-1:LW];
    endcase
  end

  always_comb begin
    priority if (cmd.load) begin
      raddr = start_word;
    end else if (cmd.scan) begin
      raddr = next_word;
    end else begin
      raddr = word_addr_r;
    end
  end

  always_comb begin
    word_addr_nxt = word_addr_r;
    priority if (cmd.clear) begin
      word_addr_nxt = status.clear_done ? '0 : word_addr_r + AW'(1);
    end else if (cmd.load) begin
      word_addr_nxt = start_word;
    end else if (cmd.scan) begin
      word_addr_nxt = next_word;
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = rd_data_r;
    priority if (cmd.clear) begin
      we    = 1'b1;
      wdata = '0;
    end else if (cmd.scan && hit) begin
      we    = 1'b1;
      wdata = rd_data_r | (WW'(1) << hit_idx);
    end else if (cmd.scan && free_ok) begin
      we    = 1'b1;
      wdata = rd_data_r & ~(WW'(1) << frame_r[LW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[word_addr_r] <= wdata;
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_addr_r  <= '0;
      pass2_r      <= 1'b0;
      khint_r      <= '0;
      uhint_r      <= FW'(tfa_pkg::KERNEL_REGION);
      reserved_r   <= tfa_pkg::RESERVED_RST;
      hole_start_r <= tfa_pkg::HOLE_START_RST;
      hole_end_r   <= tfa_pkg::HOLE_END_RST;
      out_valid_r  <= 1'b0;
    end else begin
      word_addr_r <= word_addr_nxt;
      if (cmd.load) pass2_r <= 1'b0;
      else if (cmd.scan) pass2_r <= pass2_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          tfa_pkg::CFG_RESERVED:   reserved_r   <= cfg_wdata;
          tfa_pkg::CFG_HOLE_START: hole_start_r <= cfg_wdata;
          tfa_pkg::CFG_HOLE_END:   hole_end_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.scan && hit) begin
        if (is_user) begin
          uhint_r <= (alloc_inc >= CW'(tfa_pkg::NUM_FRAMES)) ?
                     FW'(tfa_pkg::KERNEL_REGION) : alloc_inc[FW-1:0];
        end else begin
          khint_r <= (alloc_inc >= CW'(tfa_pkg::KERNEL_REGION)) ? '0 : alloc_inc[FW-1:0];
        end
      end else if (cmd.scan && free_ok) begin
        if (CW'(frame_r) < CW'(tfa_pkg::KERNEL_REGION)) khint_r <= frame_r;
        else uhint_r <= frame_r;
      end
      out_valid_r <= cmd.scan && finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      frame_r <= in_frame;
    end
    if (cmd.scan && finish) begin
      priority if (hit) begin
        out_ok_r    <= 1'b1;
        out_frame_r <= alloc_frame;
      end else if (free_ok) begin
        out_ok_r    <= 1'b1;
        out_frame_r <= frame_r;
      end else begin
        out_ok_r    <= 1'b0;
        out_frame_r <= '0;
      end
    end
  end

  assign status.clear_done = cmd.clear && (word_addr_r == AW'(tfa_pkg::WORDS - 1));
  assign status.finish     = finish;

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_frame_out = out_frame_r;

endmodule

>>> design/two_region_frame_allocator.sv
// Top level of the two-region next-fit page frame allocator.
// A free or an unused opcode finishes in its first scan state; its result strobe is registered.
// An allocation reads one 32-frame map word per cycle from its region's hint, wrapping once to the region's
// base, and stops at the first usable frame or when the second pass is back at the hint's word.
// One transaction at a time; the next one is taken in the cycle of the result strobe.
// After reset the map memory is cleared one word a cycle, all 4096 words, with busy high.
module two_region_frame_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tfa_pkg::OP_W-1:0]      in_opcode,
  input  logic [tfa_pkg::FRAME_W-1:0]   in_frame,
  output logic                          out_valid,
  output logic [tfa_pkg::FRAME_W-1:0]   out_frame_out,
  output logic                          out_ok,
  input  logic                          cfg_we,
  input  logic [tfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tfa_pkg::CFG_W-1:0]     cfg_wdata
);

  tfa_pkg::cmd_t    cmd;
  tfa_pkg::status_t status;

  tfa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tfa_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_opcode     (in_opcode),
    .in_frame      (in_frame),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_frame_out (out_frame_out),
    .out_ok        (out_ok)
  );

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("clearing pass did not start after reset");

  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not hold busy");

  a_fail_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_frame_out == '0))
    else $error("failed transaction returned a nonzero frame");

endmodule
